>>> rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Types and codes shared by the positional list unit and its storage cells.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 3'd0,
        ST_BADPOS = 3'd1,
        ST_FULL   = 3'd2,
        ST_ENTRY  = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    // Per-cycle action broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        op_t                       op;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] value_res;
        logic                      last;
    } res_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic [POS_W-1:0]          index;   // 0-based insert/delete slot
        logic [POS_W-1:0]          tail;    // last occupied slot during rotate
        logic signed [VALUE_W-1:0] value;   // value written at the insert slot
    } cell_ctrl_t;

endpackage

>>> rtl/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell
// One slot of the list: holds one entry and moves it to or from its
// neighbors as the broadcast action says.
// ----------------------------------------------------------------------------
module plid_cell
    import plid_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic signed [VALUE_W-1:0] left,
    input  logic signed [VALUE_W-1:0] right,
    input  logic signed [VALUE_W-1:0] head,
    output logic signed [VALUE_W-1:0] data
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CELL_INSERT:
            begin
                if (MY_IDX == ctrl.index)
                begin
                    data_next = ctrl.value;
                end
                else if (MY_IDX > ctrl.index)
                begin
                    data_next = left;
                end
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= ctrl.index)
                begin
                    data_next = right;
                end
            end
            CELL_ROTATE:
            begin
                // wrap the head entry around to the tail of the occupied part
                if (MY_IDX == ctrl.tail)
                begin
                    data_next = head;
                end
                else if (MY_IDX < ctrl.tail)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/positional_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_unit
// Ordered list of signed 32-bit values with insert, delete, dump and clear.
// ----------------------------------------------------------------------------
// A command transfers at a clock edge with start high and busy low. Insert,
// delete and clear each give a single result (strobed by result_valid)
// that appears in the next cycle, and busy stays low, so a command may
// follow every cycle. A dump of N entries keeps busy high in the dump state
// and strobes one entry per cycle, last set on the final one; a dump of an
// empty list gives one result and busy stays low. The dump rate is set by
// the cell chain, which rotates one entry per cycle past the head cell and
// is back in order when the dump ends. The receiver cannot stall: every
// result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_unit
    import plid_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic result_valid,
    output res_t result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [IDX_W-1:0] dump_reg,   dump_next;
    logic             valid_reg,  valid_next;
    res_t             result_reg, result_next;

    cell_ctrl_t                ctrl;
    logic signed [VALUE_W-1:0] cell_data [CAPACITY];

    logic [POS_W-1:0] count_pos;
    logic [CNT_W-1:0] count_m1;
    logic             accept;
    logic             ins_ok;
    logic             del_ok;
    logic             dump_last;

    assign count_pos = POS_W'(count_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign accept    = start && (state_reg == S_IDLE);
    assign ins_ok    = ((cmd.position >= POS_W'(1)) && (cmd.position <= count_pos))
                    || ((cmd.position == POS_W'(1)) && (count_reg == '0));
    assign del_ok    = (cmd.position >= POS_W'(1)) && (cmd.position <= count_pos);
    assign dump_last = (CNT_W'(dump_reg) == count_m1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        dump_next   = dump_reg;
        valid_next  = 1'b0;
        result_next = result_reg;

        ctrl.cmd   = CELL_HOLD;
        ctrl.index = cmd.position - POS_W'(1);
        ctrl.tail  = POS_W'(count_m1);
        ctrl.value = cmd.value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.value_res = '0;
                    result_next.last      = 1'b1;
                    result_next.status    = ST_DONE;
                    valid_next            = 1'b1;
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (!ins_ok)
                            begin
                                result_next.status = ST_BADPOS;
                            end
                            else if (count_reg == CAP_CNT)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.cmd   = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!del_ok)
                            begin
                                result_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.cmd   = CELL_DELETE;
                                count_next = count_m1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                // entries follow from the dump state
                                valid_next = 1'b0;
                                dump_next  = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                ctrl.cmd              = CELL_ROTATE;
                valid_next            = 1'b1;
                result_next.status    = ST_ENTRY;
                result_next.value_res = cell_data[0];
                result_next.last      = dump_last;
                dump_next             = dump_reg + IDX_W'(1);
                if (dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            dump_reg   <= '0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            dump_reg   <= dump_next;
            valid_reg  <= valid_next;
            result_reg <= result_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_inner_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_final
            assign right_in = '0;
        end
        else
        begin : g_inner_r
            assign right_in = cell_data[i+1];
        end

        plid_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_in),
            .right (right_in),
            .head  (cell_data[0]),
            .data  (cell_data[i])
        );
    end

    assign busy         = (state_reg == S_DUMP);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
